// ----- rtl/core/swe_pkg.sv -----
// ----------------------------------------------------------------------------
// swe_pkg: shared types and constants of the stereo width estimator.
// Holds the sample and sum widths, the controller states and the command
// and status records that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package swe_pkg;

	// Fixed widths of the item fields and of the accumulators.
	localparam int SAMPLE_BITS      = 24;
	localparam int STEP_W           = 16;
	localparam int SUM_W            = 64;
	localparam int PROD_W           = 2 * SUM_W;
	localparam int WIDE_W           = 162;
	localparam int Q_W              = 16;
	localparam int MAX_SELECTED_DEF = 2048;

	// Number of 32x32 partial products for the two 64x64 products.
	localparam logic [3:0] MUL_LAST = 4'd8;
	// Top bit of the correlation magnitude search.
	localparam logic [3:0] BIT_TOP  = 4'd15;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_FLUSH,
		ST_CHECK,
		ST_MUL,
		ST_INIT,
		ST_SRCH,
		ST_DONE
	} swe_state_t;

	// Sub-steps of one bit of the magnitude search.
	typedef enum logic [1:0] {
		SP_ADD,
		SP_SUM,
		SP_CMP
	} swe_sphase_t;

	typedef struct packed {
		logic        acc_en;
		logic        check;
		logic        mul_clear;
		logic        mul_issue;
		logic [2:0]  mul_idx;
		logic        srch_init;
		logic        srch_en;
		swe_sphase_t srch_phase;
		logic [3:0]  srch_bit;
		logic        load_out;
		logic        clear;
		logic        ovf;
	} swe_cmd_t;

	typedef struct packed {
		logic zero;
		logic accept;
	} swe_stat_t;

endpackage

// ----- rtl/core/swe_in_if.sv -----
// ----------------------------------------------------------------------------
// swe_in_if: sample pair channel.
// Carries one stereo sample pair and its end-of-buffer mark per item.
// ----------------------------------------------------------------------------
interface swe_in_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] left_sample;
	logic signed [23:0] right_sample;
	logic               last_sample;

	modport source(output valid, left_sample, right_sample, last_sample, input ready);
	modport sink(input valid, left_sample, right_sample, last_sample, output ready);
endinterface

// ----- rtl/core/swe_out_if.sv -----
// ----------------------------------------------------------------------------
// swe_out_if: result channel.
// Carries the width and correlation of one finished buffer per item.
// ----------------------------------------------------------------------------
interface swe_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        stereo_width;
	logic signed [15:0] correlation;
	logic               width_valid;
	logic               count_overflow;

	modport source(output valid, stereo_width, correlation, width_valid, count_overflow,
		input ready);
	modport sink(input valid, stereo_width, correlation, width_valid, count_overflow,
		output ready);
endinterface

// ----- rtl/core/swe_cfg_if.sv -----
// ----------------------------------------------------------------------------
// swe_cfg_if: configuration write channel.
// Carries the decimation step register value.
// ----------------------------------------------------------------------------
interface swe_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] decimation_step;

	modport source(output valid, decimation_step, input ready);
	modport sink(input valid, decimation_step, output ready);
endinterface

// ----- rtl/core/stereo_width_estimator.sv -----
// ----------------------------------------------------------------------------
// stereo_width_estimator: stereo phase correlation and width meter.
// Accumulates decimated energy and cross sums and reports correlation and
// width in Q1.15 at the end of each buffer.
// ----------------------------------------------------------------------------
// Sample pairs are taken one per cycle while a buffer accumulates. The pair
// marked last stops intake: a flush state settles the sums, a check state
// tests the energy sums, the 128-bit products L*R and C*C are formed on one
// 32x32 multiplier, an init state loads the search, and the magnitude search
// runs add, sum and compare steps per result bit over up to 16 bits; a zero
// energy sum skips both. Intake stays off until the result is loaded, and
// longer while an earlier result still waits to be taken. A finished result
// waits in the output register; a new buffer may accumulate meanwhile.
module stereo_width_estimator
	import swe_pkg::*;
#(
	parameter int MAX_SELECTED = MAX_SELECTED_DEF
) (
	input logic    clk,
	input logic    arst_n,
	swe_cfg_if.sink cfg,
	swe_in_if.sink  samples,
	swe_out_if.source results
);

	swe_cmd_t  cmd;
	swe_stat_t stat;

	swe_ctrl #(
		.MAX_SELECTED(MAX_SELECTED)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cfg_step  (cfg.decimation_step),
		.in_valid  (samples.valid),
		.in_last   (samples.last_sample),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	swe_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.left_sample    (samples.left_sample),
		.right_sample   (samples.right_sample),
		.cmd            (cmd),
		.stat           (stat),
		.stereo_width   (results.stereo_width),
		.correlation    (results.correlation),
		.width_valid    (results.width_valid),
		.count_overflow (results.count_overflow)
	);

`ifndef ASSERT_OFF
	// Intake stops right after the end of a buffer.
	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready && samples.last_sample |=> !samples.ready)
		else $error("pair accepted right after end of buffer");

	// A result without valid energy carries zero width and correlation.
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.width_valid |->
		results.stereo_width == 16'd0 && results.correlation == 16'sd0)
		else $error("zero-energy result carries nonzero fields");

	// Width never exceeds one.
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.stereo_width <= 16'h8000)
		else $error("width above one");

	// A positive correlation and the width add up to one, or saturate.
	a_width_sum: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.width_valid && !results.correlation[15] |->
		(17'(results.stereo_width) + 17'(unsigned'(results.correlation)) == 17'h08000) ||
		(results.correlation == 16'sh7FFF && results.stereo_width == 16'd0))
		else $error("width and correlation disagree");
`endif

endmodule

// ----- rtl/core/swe_ctrl.sv -----
// ----------------------------------------------------------------------------
// swe_ctrl: controller of the stereo width estimator.
// Holds the decimation register, the decimation phase, the kept-pair count
// and the sequencer that walks the datapath through the result computation.
// ----------------------------------------------------------------------------
module swe_ctrl
	import swe_pkg::*;
#(
	parameter int MAX_SELECTED = MAX_SELECTED_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [STEP_W-1:0] cfg_step,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output swe_cmd_t  cmd,
	input  swe_stat_t stat
);

	localparam int KEPT_W = $clog2(MAX_SELECTED + 1);

	swe_state_t        state_q, state_nxt;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] phase_q;
	logic [STEP_W:0]   phase_inc;
	logic [KEPT_W-1:0] kept_q;
	logic              ovf_q;
	logic              ovf_res_q;
	logic [3:0]        cnt_q;
	swe_sphase_t       ph_q;
	logic              out_valid_q;
	logic              acc;
	logic              pick;
	logic              room;
	logic              fire;
	logic              srch_end;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_ACCUM);
	assign out_valid = out_valid_q;
	assign acc       = in_valid && in_ready;
	assign pick      = (phase_q == '0);
	assign room      = (kept_q < KEPT_W'(MAX_SELECTED));
	assign phase_inc = {1'b0, phase_q} + 1'b1;
	assign fire      = !out_valid_q || out_ready;
	assign srch_end  = (ph_q == SP_CMP) &&
		((cnt_q == 4'd0) || ((cnt_q == BIT_TOP) && stat.accept));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		cmd.srch_phase = ph_q;
		cmd.srch_bit   = cnt_q;
		cmd.mul_idx    = cnt_q[2:0];
		cmd.ovf        = ovf_res_q;
		unique case (state_q)
			ST_ACCUM: begin
				cmd.acc_en = acc && pick && room;
				if (acc && in_last) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check     = 1'b1;
				cmd.mul_clear = 1'b1;
				state_nxt     = stat.zero ? ST_DONE : ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_issue = (cnt_q != MUL_LAST);
				if (cnt_q == MUL_LAST) begin
					state_nxt = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.srch_init = 1'b1;
				state_nxt     = ST_SRCH;
			end
			ST_SRCH: begin
				cmd.srch_en = 1'b1;
				if (srch_end) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (fire) begin
					cmd.load_out = 1'b1;
					cmd.clear    = 1'b1;
					state_nxt    = ST_ACCUM;
				end
			end
			default: begin
				state_nxt = ST_ACCUM;
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			step_q <= cfg_step;
		end
	end

	// Decimation phase, kept-pair count and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			kept_q    <= '0;
			ovf_q     <= 1'b0;
			ovf_res_q <= 1'b0;
		end else if (acc) begin
			if (in_last) begin
				phase_q   <= '0;
				kept_q    <= '0;
				ovf_q     <= 1'b0;
				ovf_res_q <= ovf_q || (pick && !room);
			end else begin
				phase_q <= (phase_inc >= {1'b0, step_q}) ? '0 : phase_inc[STEP_W-1:0];
				if (pick && room) begin
					kept_q <= kept_q + 1'b1;
				end
				if (pick && !room) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// Step counter for the multiplier and the search bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ph_q  <= SP_ADD;
		end else begin
			unique case (state_q)
				ST_CHECK: cnt_q <= '0;
				ST_MUL:   cnt_q <= cnt_q + 1'b1;
				ST_INIT: begin
					cnt_q <= BIT_TOP;
					ph_q  <= SP_ADD;
				end
				ST_SRCH: begin
					unique case (ph_q)
						SP_ADD: ph_q <= SP_SUM;
						SP_SUM: ph_q <= SP_CMP;
						SP_CMP: begin
							ph_q  <= SP_ADD;
							cnt_q <= cnt_q - 1'b1;
						end
						default: ph_q <= SP_ADD;
					endcase
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/swe_dp.sv -----
// ----------------------------------------------------------------------------
// swe_dp: datapath of the stereo width estimator.
// Accumulates the energy and cross sums, forms the two 128-bit products from
// 32x32 partial products and finds the correlation magnitude bit by bit.
// ----------------------------------------------------------------------------
module swe_dp
	import swe_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  swe_cmd_t                      cmd,
	output swe_stat_t                     stat,
	output logic [15:0]                   stereo_width,
	output logic signed [15:0]            correlation,
	output logic                          width_valid,
	output logic                          count_overflow
);

	localparam int MP_W = 2 * SAMPLE_BITS;

	// Accumulation stage.
	logic signed [MP_W-1:0] ll_s1, rr_s1, lr_s1;
	logic                   v_s1;
	logic [SUM_W-1:0]       lsum_q, rsum_q, csum_q;

	// Product stage.
	logic [SUM_W-1:0]  cmag_q;
	logic              neg_q;
	logic              zero_q;
	logic [SUM_W-1:0]  opa, opb;
	logic [31:0]       a32, b32;
	logic [63:0]       pp_s1;
	logic [2:0]        pidx_s1;
	logic              ppv_s1;
	logic [PROD_W-1:0] pp_sh;
	logic [PROD_W-1:0] p_q, cc_q;

	// Search stage.
	logic [WIDE_W-1:0] s_q, u_q, pb_q, rhs_q, y_q, u2_q;
	logic [WIDE_W-1:0] u_new;
	logic [Q_W-1:0]    q_q;
	logic              accept;

	assign stat.zero   = (lsum_q == '0) || (rsum_q == '0);
	assign accept      = (y_q <= rhs_q);
	assign stat.accept = accept;

	// Products of one kept pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.acc_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			ll_s1 <= left_sample * left_sample;
			rr_s1 <= right_sample * right_sample;
			lr_s1 <= left_sample * right_sample;
		end
	end

	// Wrapping 64-bit sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_q <= '0;
			rsum_q <= '0;
			csum_q <= '0;
		end else if (cmd.clear) begin
			lsum_q <= '0;
			rsum_q <= '0;
			csum_q <= '0;
		end else if (v_s1) begin
			lsum_q <= lsum_q + SUM_W'(ll_s1);
			rsum_q <= rsum_q + SUM_W'(rr_s1);
			csum_q <= csum_q + SUM_W'(lr_s1);
		end
	end

	// Cross magnitude and sign, captured once the sums are final.
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			neg_q  <= csum_q[SUM_W-1];
			cmag_q <= csum_q[SUM_W-1] ? (~csum_q + 1'b1) : csum_q;
			zero_q <= stat.zero;
		end
	end

	// Partial product select: bit 2 picks the cross square, bits 1:0 the halves.
	always_comb begin
		opa = cmd.mul_idx[2] ? cmag_q : lsum_q;
		opb = cmd.mul_idx[2] ? cmag_q : rsum_q;
		a32 = cmd.mul_idx[0] ? opa[63:32] : opa[31:0];
		b32 = cmd.mul_idx[1] ? opb[63:32] : opb[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppv_s1 <= 1'b0;
		end else begin
			ppv_s1 <= cmd.mul_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_issue) begin
			pp_s1   <= a32 * b32;
			pidx_s1 <= cmd.mul_idx;
		end
	end

	// Align the partial product by the weight of its halves.
	always_comb begin
		case ({1'b0, pidx_s1[0]} + {1'b0, pidx_s1[1]})
			2'd0:    pp_sh = PROD_W'(pp_s1);
			2'd1:    pp_sh = PROD_W'(pp_s1) << 32;
			default: pp_sh = PROD_W'(pp_s1) << 64;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_clear) begin
			p_q  <= '0;
			cc_q <= '0;
		end else if (ppv_s1) begin
			if (pidx_s1[2]) begin
				cc_q <= cc_q + pp_sh;
			end else begin
				p_q <= p_q + pp_sh;
			end
		end
	end

	// Bit-serial search for the largest q with q*q*L*R <= 2^30*C*C.
	// s_q holds q*q*P, u_q holds q*P shifted up by bit+1, pb_q holds P shifted
	// up by twice the bit, so each trial is s + u + pb.
	assign u_new = accept ? u2_q : u_q;

	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			s_q   <= '0;
			u_q   <= '0;
			pb_q  <= WIDE_W'(p_q) << 30;
			rhs_q <= WIDE_W'(cc_q) << 30;
			q_q   <= '0;
		end else if (cmd.srch_en) begin
			case (cmd.srch_phase)
				SP_ADD: begin
					y_q <= s_q + u_q;
				end
				SP_SUM: begin
					y_q  <= y_q + pb_q;
					u2_q <= u_q + (pb_q << 1);
				end
				SP_CMP: begin
					if (accept) begin
						s_q <= y_q;
						q_q <= q_q | (Q_W'(1) << cmd.srch_bit);
					end
					u_q  <= u_new >> 1;
					pb_q <= pb_q >> 2;
				end
				default: begin
					y_q <= y_q;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			count_overflow <= cmd.ovf;
			width_valid    <= !zero_q;
			if (zero_q) begin
				stereo_width <= '0;
				correlation  <= '0;
			end else begin
				stereo_width <= 16'h8000 - q_q;
				if (neg_q) begin
					correlation <= $signed(16'h0000 - q_q);
				end else if (q_q[15]) begin
					correlation <= 16'sh7FFF;
				end else begin
					correlation <= $signed(q_q);
				end
			end
		end
	end

endmodule

// ----- test/tb_swe_ifs.sv -----
// ----------------------------------------------------------------------------
// tb_swe_ifs: testbench constants.
// The block's own interface files are compiled with the RTL; this file only
// holds the settling time the testbench waits after each drained phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tb_swe_ifs_pkg;
	localparam int RESULT_LATENCY = 80;
endpackage

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the stereo width estimator.
// Drives sample pairs and decimation settings, predicts each buffer's
// correlation and width with an exact integer search, and compares every
// result item field by field under random idling and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
	import swe_pkg::*;
	import tb_swe_ifs_pkg::*;

	typedef struct packed {
		logic signed [23:0] left_s;
		logic signed [23:0] right_s;
		logic               last_s;
	} pair_t;

	typedef struct packed {
		logic [15:0]        width;
		logic signed [15:0] corr;
		logic               wvalid;
		logic               ovf;
	} meter_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	swe_cfg_if cfg_ch();
	swe_in_if  in_ch();
	swe_out_if out_ch();

	stereo_width_estimator DUT (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_ch.sink), .samples(in_ch.sink),
		.results(out_ch.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	pair_t  pending_pairs[$];
	meter_t expected_meters[$];
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     hold_off = 0;
	int     quiet_cycles = 0;
	int     fail_count = 0;
	logic   in_took = 1'b0;

	// Predictor state.
	logic [15:0] step_reg;
	logic [15:0] phase;
	logic [63:0] left_acc, right_acc, cross_acc;
	int          kept;
	logic        dropped;

	function automatic void clear_meter();
		phase = 0; left_acc = 0; right_acc = 0; cross_acc = 0; kept = 0; dropped = 0;
	endfunction

	// Exact magnitude search: largest q with q*q*L*R <= 2^30 * cross^2.
	function automatic void predict_pair(pair_t p);
		logic [63:0]  l, r, mag;
		logic [15:0]  eff;
		logic [191:0] lr, rhs, qq;
		int           lo, hi, mid;
		meter_t       m;
		eff = (step_reg == 0) ? 16'd1 : step_reg;
		if (phase == 0) begin
			if (kept < 2048) begin
				l = {{40{p.left_s[23]}}, p.left_s};
				r = {{40{p.right_s[23]}}, p.right_s};
				left_acc += l * l;
				right_acc += r * r;
				cross_acc += l * r;
				kept++;
			end else begin
				dropped = 1'b1;
			end
		end
		phase++;
		if (phase >= eff)
			phase = 0;
		if (!p.last_s)
			return;
		if (left_acc == 0 || right_acc == 0) begin
			m = '0;
		end else begin
			mag = cross_acc[63] ? -cross_acc : cross_acc;
			lr = 192'(left_acc) * 192'(right_acc);
			rhs = (192'(mag) * 192'(mag)) << 30;
			lo = 0; hi = 32768;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				qq = 192'(mid * mid) * lr;
				if (qq <= rhs)
					lo = mid;
				else
					hi = mid - 1;
			end
			m.width = 16'(32768 - lo);
			if (cross_acc[63])
				m.corr = 16'(65536 - lo);
			else
				m.corr = (lo > 32767) ? 16'sd32767 : 16'(lo);
			m.wvalid = 1'b1;
		end
		m.ovf = dropped;
		expected_meters.push_back(m);
		clear_meter();
	endfunction

	// Input handshake seen at the rising edge, used by the driver afterwards.
	always @(posedge clk) begin
		in_took <= in_ch.valid && in_ch.ready;
	end

	// Sample-pair driver: changes inputs on the falling edge.
	always @(negedge clk) begin
		if (in_took) begin
			predict_pair(pending_pairs.pop_front());
		end
		if (in_ch.valid && !in_took) begin
			// The offered item waits unchanged until it is taken.
			in_ch.valid <= 1'b1;
		end else if (pending_pairs.size() > 0 && ($urandom_range(99) >= send_idle_pct)) begin
			in_ch.valid <= 1'b1;
			in_ch.left_sample <= pending_pairs[0].left_s;
			in_ch.right_sample <= pending_pairs[0].right_s;
			in_ch.last_sample <= pending_pairs[0].last_s;
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Result sink ready, with random stalls and the long hold-off.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Result monitor and watchdog.
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (expected_meters.size() == 0) begin
				$error("unexpected result item");
				fail_count++;
			end else begin
				meter_t e;
				e = expected_meters.pop_front();
				if (out_ch.stereo_width !== e.width) begin
					$error("stereo_width exp %0d got %0d", e.width, out_ch.stereo_width);
					fail_count++;
				end
				if (out_ch.correlation !== e.corr) begin
					$error("correlation exp %0d got %0d", e.corr, out_ch.correlation);
					fail_count++;
				end
				if (out_ch.width_valid !== e.wvalid) begin
					$error("width_valid exp %0d got %0d", e.wvalid, out_ch.width_valid);
					fail_count++;
				end
				if (out_ch.count_overflow !== e.ovf) begin
					$error("count_overflow exp %0d got %0d", e.ovf, out_ch.count_overflow);
					fail_count++;
				end
			end
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'(int'($urandom_range(255)) - 128);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic add_pair(logic signed [23:0] l, logic signed [23:0] r, logic last);
		pair_t p;
		p.left_s = l; p.right_s = r; p.last_s = last;
		pending_pairs.push_back(p);
	endtask

	// Random buffer: equal, opposite, sparse or independent channels.
	task automatic add_buffer(int len);
		int    k;
		int    mode;
		logic signed [23:0] l;
		mode = $urandom_range(3);
		for (k = 0; k < len; k++) begin
			l = rand_sample();
			case (mode)
				0: add_pair(l, l, k == len - 1);
				1: add_pair(l, -l, k == len - 1);
				2: add_pair(l, 24'($urandom_range(1)) ? rand_sample() : 24'sd0, k == len - 1);
				default: add_pair(l, rand_sample(), k == len - 1);
			endcase
		end
	endtask

	task automatic drain();
		wait (pending_pairs.size() == 0 && !in_ch.valid);
		wait (expected_meters.size() == 0);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	task automatic write_step(logic [15:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.decimation_step <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		step_reg = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int b;
		logic [15:0] steps[6];
		steps = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2, 16'd7};
		in_ch.valid = 1'b0;
		in_ch.left_sample = '0;
		in_ch.right_sample = '0;
		in_ch.last_sample = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.decimation_step = '0;
		step_reg = 16'd1;
		clear_meter();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, zero energy, sign cases, single- and two-pair buffers.
		add_pair(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
		add_pair(24'sh800000, 24'sh7FFFFF, 1'b1);
		add_pair(24'sh800000, 24'sh800000, 1'b1);
		add_pair(24'sd0, 24'sh123456, 1'b1);
		add_pair(24'sh123456, 24'sd0, 1'b1);
		add_pair(24'sd0, 24'sd0, 1'b1);
		add_pair(24'sd1, 24'sd1, 1'b0);
		add_pair(24'sd1, -24'sd1, 1'b1);
		add_pair(24'sh7FFFFF, 24'sd1, 1'b0);
		add_pair(24'sd1, 24'sh7FFFFF, 1'b1);
		add_pair(-24'sd5, 24'sd3, 1'b0);
		add_pair(24'sd2, 24'sd7, 1'b1);
		drain();

		// Random phases over the decimation settings and idling mixes.
		for (b = 0; b < 6; b++) begin
			write_step(steps[b]);
			case (b % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			repeat (12) add_buffer($urandom_range(1, 36));
			if (b == 0) begin
				// Long receiver hold-off while pairs keep coming.
				hold_off = 400;
				repeat (6) add_buffer($urandom_range(1, 4));
			end
			drain();
		end

		// A final longer buffer at the shortest step.
		write_step(16'd1);
		send_idle_pct = 10; recv_stall_pct = 10;
		add_buffer(100);
		drain();

		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
